### hdl/ffc_pkg.sv
package ffc_pkg;

  localparam int YAW_FULL    = 1474560;
  localparam int HALF_TURN   = 737280;
  localparam int QUARTER     = 368640;
  localparam int PITCH_LIMIT = 364544;
  localparam int Q14_ONE     = 16384;
  localparam int CORDIC_X0   = 652032874;
  localparam int MOD_STEPS   = 12;
  localparam logic [34:0] YAW_BIAS   = 35'd3019898880;
  localparam logic [32:0] YAW_DV0    = 33'd3019898880;
  localparam logic [33:0] NR_THREE   = 34'd3221225472;

  localparam logic [1:0] CFG_MOVE_SPEED   = 2'd0;
  localparam logic [1:0] CFG_BOOST_FACTOR = 2'd1;
  localparam logic [1:0] CFG_LOOK_SENS    = 2'd2;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_MUL, OP_YPREP, OP_PITCH, OP_MOD, OP_CINIT, OP_CSTEP,
    OP_CDONE, OP_FX, OP_FZ, OP_DSET, OP_DADD, OP_SACC, OP_NINIT, OP_NORM,
    OP_SEED, OP_NY2, OP_NF, OP_NY, OP_UNIT, OP_SPEED, OP_MOVE, OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    M_YAW, M_PITCH, M_FX, M_FZ, M_DA, M_DB, M_SQ, M_YY, M_MY2, M_YF, M_DY,
    M_SPD, M_US, M_PDT
  } msel_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_YMUL, ST_YPREP, ST_PMUL, ST_PITCH, ST_MOD, ST_CINIT, ST_CSTEP,
    ST_CDONE, ST_FXMUL, ST_FX, ST_FZMUL, ST_FZ, ST_DAMUL, ST_DSET, ST_DBMUL,
    ST_DADD, ST_SQMUL, ST_SACC, ST_ZCHK, ST_NORM, ST_SEED, ST_N1MUL, ST_NY2,
    ST_N2MUL, ST_NF, ST_N3MUL, ST_NY, ST_UMUL, ST_UNIT, ST_SPMUL, ST_SPEED,
    ST_M1MUL, ST_M2MUL, ST_MOVE, ST_DONE
  } ctl_state_t;

  typedef struct packed {
    op_t        op;
    msel_t      msel;
    logic [1:0] k;
    logic [4:0] step;
  } ctl_cmd_t;

  typedef struct packed {
    logic s_zero;
    logic norm_done;
    logic out_free;
  } ctl_stat_t;

  function automatic logic [25:0] atan_deg20(input logic [4:0] i);
    logic [25:0] v;
    case (i)
      5'd0:  v = 26'd47185920;
      5'd1:  v = 26'd27855475;
      5'd2:  v = 26'd14718068;
      5'd3:  v = 26'd7471121;
      5'd4:  v = 26'd3750058;
      5'd5:  v = 26'd1876857;
      5'd6:  v = 26'd938658;
      5'd7:  v = 26'd469357;
      5'd8:  v = 26'd234682;
      5'd9:  v = 26'd117342;
      5'd10: v = 26'd58671;
      5'd11: v = 26'd29335;
      5'd12: v = 26'd14668;
      5'd13: v = 26'd7334;
      5'd14: v = 26'd3667;
      5'd15: v = 26'd1833;
      5'd16: v = 26'd917;
      5'd17: v = 26'd458;
      5'd18: v = 26'd229;
      5'd19: v = 26'd115;
      5'd20: v = 26'd57;
      5'd21: v = 26'd29;
      5'd22: v = 26'd14;
      5'd23: v = 26'd7;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

  function automatic logic [14:0] rsqrt_seed(input logic [3:0] i);
    logic [14:0] v;
    case (i)
      4'd0:  v = 15'd30894;
      4'd1:  v = 15'd27944;
      4'd2:  v = 15'd25707;
      4'd3:  v = 15'd23930;
      4'd4:  v = 15'd22479;
      4'd5:  v = 15'd21263;
      4'd6:  v = 15'd20225;
      4'd7:  v = 15'd19326;
      4'd8:  v = 15'd18537;
      4'd9:  v = 15'd17836;
      4'd10: v = 15'd17210;
      4'd11: v = 15'd16646;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

### hdl/ffc_if.sv
interface ffc_frame_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] forward_axis;
  logic signed [15:0] right_axis;
  logic signed [15:0] up_axis;
  logic        [15:0] time_step;
  logic               boost_on;
  logic signed [15:0] mouse_dx;
  logic signed [15:0] mouse_dy;
  modport source (output valid, forward_axis, right_axis, up_axis, time_step, boost_on,
                  mouse_dx, mouse_dy, input ready);
  modport sink (input valid, forward_axis, right_axis, up_axis, time_step, boost_on,
                mouse_dx, mouse_dy, output ready);
endinterface

interface ffc_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] fwd_x;
  logic signed [15:0] fwd_y;
  logic signed [15:0] fwd_z;
  logic        [20:0] yaw_angle;
  logic signed [19:0] pitch_angle;
  modport source (output valid, pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z, yaw_angle,
                  pitch_angle, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z, yaw_angle,
                pitch_angle, output ready);
endinterface

interface ffc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/ffc_ctrl.sv
module ffc_ctrl #(
  parameter int CORDIC_STEPS = 16,
  parameter int RSQRT_STEPS  = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffc_pkg::ctl_stat_t  stat,
  output ffc_pkg::ctl_cmd_t   cmd
);

  localparam logic [4:0] CS_LAST  = 5'(CORDIC_STEPS - 1);
  localparam logic [4:0] NR_LAST  = 5'(RSQRT_STEPS - 1);
  localparam logic [4:0] MOD_LAST = 5'(ffc_pkg::MOD_STEPS - 1);

  ffc_pkg::ctl_state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffc_pkg::ST_IDLE;
      cnt   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    k_next     = k;
    in_ready   = 1'b0;
    cmd.op     = ffc_pkg::OP_NOP;
    cmd.msel   = ffc_pkg::M_YAW;
    cmd.k      = k;
    cmd.step   = cnt;
    case (state)
      ffc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = ffc_pkg::OP_LOAD;
          state_next = ffc_pkg::ST_YMUL;
        end
      end
      ffc_pkg::ST_YMUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_YAW;
        state_next = ffc_pkg::ST_YPREP;
      end
      ffc_pkg::ST_YPREP: begin
        cmd.op = ffc_pkg::OP_YPREP;
        state_next = ffc_pkg::ST_PMUL;
      end
      ffc_pkg::ST_PMUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_PITCH;
        state_next = ffc_pkg::ST_PITCH;
      end
      ffc_pkg::ST_PITCH: begin
        cmd.op = ffc_pkg::OP_PITCH;
        cnt_next = '0;
        state_next = ffc_pkg::ST_MOD;
      end
      ffc_pkg::ST_MOD: begin
        cmd.op = ffc_pkg::OP_MOD;
        if (cnt == MOD_LAST) begin
          cnt_next = '0;
          k_next = 2'd0;
          state_next = ffc_pkg::ST_CINIT;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      ffc_pkg::ST_CINIT: begin
        cmd.op = ffc_pkg::OP_CINIT;
        cnt_next = '0;
        state_next = ffc_pkg::ST_CSTEP;
      end
      ffc_pkg::ST_CSTEP: begin
        cmd.op = ffc_pkg::OP_CSTEP;
        if (cnt == CS_LAST) begin
          state_next = ffc_pkg::ST_CDONE;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      ffc_pkg::ST_CDONE: begin
        cmd.op = ffc_pkg::OP_CDONE;
        if (k == 2'd0) begin
          k_next = 2'd1;
          state_next = ffc_pkg::ST_CINIT;
        end else begin
          state_next = ffc_pkg::ST_FXMUL;
        end
      end
      ffc_pkg::ST_FXMUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_FX;
        state_next = ffc_pkg::ST_FX;
      end
      ffc_pkg::ST_FX: begin
        cmd.op = ffc_pkg::OP_FX;
        state_next = ffc_pkg::ST_FZMUL;
      end
      ffc_pkg::ST_FZMUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_FZ;
        state_next = ffc_pkg::ST_FZ;
      end
      ffc_pkg::ST_FZ: begin
        cmd.op = ffc_pkg::OP_FZ;
        k_next = 2'd0;
        state_next = ffc_pkg::ST_DAMUL;
      end
      ffc_pkg::ST_DAMUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_DA;
        state_next = ffc_pkg::ST_DSET;
      end
      ffc_pkg::ST_DSET: begin
        cmd.op = ffc_pkg::OP_DSET;
        state_next = ffc_pkg::ST_DBMUL;
      end
      ffc_pkg::ST_DBMUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_DB;
        state_next = ffc_pkg::ST_DADD;
      end
      ffc_pkg::ST_DADD: begin
        cmd.op = ffc_pkg::OP_DADD;
        if (k == 2'd2) begin
          k_next = 2'd0;
          state_next = ffc_pkg::ST_SQMUL;
        end else begin
          k_next = k + 2'd1;
          state_next = ffc_pkg::ST_DAMUL;
        end
      end
      ffc_pkg::ST_SQMUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_SQ;
        state_next = ffc_pkg::ST_SACC;
      end
      ffc_pkg::ST_SACC: begin
        cmd.op = ffc_pkg::OP_SACC;
        if (k == 2'd2) begin
          k_next = 2'd0;
          state_next = ffc_pkg::ST_ZCHK;
        end else begin
          k_next = k + 2'd1;
          state_next = ffc_pkg::ST_SQMUL;
        end
      end
      ffc_pkg::ST_ZCHK: begin
        cmd.op = ffc_pkg::OP_NINIT;
        state_next = stat.s_zero ? ffc_pkg::ST_DONE : ffc_pkg::ST_NORM;
      end
      ffc_pkg::ST_NORM: begin
        if (stat.norm_done) begin
          state_next = ffc_pkg::ST_SEED;
        end else begin
          cmd.op = ffc_pkg::OP_NORM;
        end
      end
      ffc_pkg::ST_SEED: begin
        cmd.op = ffc_pkg::OP_SEED;
        cnt_next = '0;
        state_next = ffc_pkg::ST_N1MUL;
      end
      ffc_pkg::ST_N1MUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_YY;
        state_next = ffc_pkg::ST_NY2;
      end
      ffc_pkg::ST_NY2: begin
        cmd.op = ffc_pkg::OP_NY2;
        state_next = ffc_pkg::ST_N2MUL;
      end
      ffc_pkg::ST_N2MUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_MY2;
        state_next = ffc_pkg::ST_NF;
      end
      ffc_pkg::ST_NF: begin
        cmd.op = ffc_pkg::OP_NF;
        state_next = ffc_pkg::ST_N3MUL;
      end
      ffc_pkg::ST_N3MUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_YF;
        state_next = ffc_pkg::ST_NY;
      end
      ffc_pkg::ST_NY: begin
        cmd.op = ffc_pkg::OP_NY;
        if (cnt == NR_LAST) begin
          k_next = 2'd0;
          state_next = ffc_pkg::ST_UMUL;
        end else begin
          cnt_next = cnt + 5'd1;
          state_next = ffc_pkg::ST_N1MUL;
        end
      end
      ffc_pkg::ST_UMUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_DY;
        state_next = ffc_pkg::ST_UNIT;
      end
      ffc_pkg::ST_UNIT: begin
        cmd.op = ffc_pkg::OP_UNIT;
        if (k == 2'd2) begin
          k_next = 2'd0;
          state_next = ffc_pkg::ST_SPMUL;
        end else begin
          k_next = k + 2'd1;
          state_next = ffc_pkg::ST_UMUL;
        end
      end
      ffc_pkg::ST_SPMUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_SPD;
        state_next = ffc_pkg::ST_SPEED;
      end
      ffc_pkg::ST_SPEED: begin
        cmd.op = ffc_pkg::OP_SPEED;
        state_next = ffc_pkg::ST_M1MUL;
      end
      ffc_pkg::ST_M1MUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_US;
        state_next = ffc_pkg::ST_M2MUL;
      end
      ffc_pkg::ST_M2MUL: begin
        cmd.op = ffc_pkg::OP_MUL; cmd.msel = ffc_pkg::M_PDT;
        state_next = ffc_pkg::ST_MOVE;
      end
      ffc_pkg::ST_MOVE: begin
        cmd.op = ffc_pkg::OP_MOVE;
        if (k == 2'd2) begin
          k_next = 2'd0;
          state_next = ffc_pkg::ST_DONE;
        end else begin
          k_next = k + 2'd1;
          state_next = ffc_pkg::ST_M1MUL;
        end
      end
      ffc_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.op = ffc_pkg::OP_OUT;
          state_next = ffc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/ffc_datapath.sv
module ffc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  ffc_pkg::ctl_cmd_t  cmd,
  output ffc_pkg::ctl_stat_t stat,
  input  logic signed [15:0] forward_axis,
  input  logic signed [15:0] right_axis,
  input  logic signed [15:0] up_axis,
  input  logic        [15:0] time_step,
  input  logic               boost_on,
  input  logic signed [15:0] mouse_dx,
  input  logic signed [15:0] mouse_dy,
  input  logic        [15:0] move_speed,
  input  logic        [11:0] boost_factor,
  input  logic        [15:0] look_sensitivity,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] fwd_x,
  output logic signed [15:0] fwd_y,
  output logic signed [15:0] fwd_z,
  output logic        [20:0] yaw_angle,
  output logic signed [19:0] pitch_angle
);

  function automatic logic signed [15:0] clamp_q14(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd16384) r = 16'sd16384;
    else if (v < -64'sd16384) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

  logic signed [15:0] fa, ra, ua, mdx, mdy;
  logic        [15:0] dt;
  logic               boost;
  logic        [20:0] yaw;
  logic signed [19:0] pitch;
  logic signed [31:0] pos0, pos1, pos2;
  logic signed [71:0] prod;
  logic        [32:0] r, dv;
  logic signed [33:0] cx, cyv;
  logic signed [31:0] cz;
  logic               cneg;
  logic signed [15:0] sin_yaw, cos_yaw, sin_pitch, cos_pitch;
  logic signed [15:0] fx, fy, fz;
  logic signed [31:0] d0, d1, d2;
  logic        [61:0] s, m;
  logic signed [6:0]  sh;
  logic        [31:0] y, y2, f;
  logic signed [15:0] u0, u1, u2;
  logic        [19:0] speed;

  logic signed [35:0] ma, mb;
  logic signed [31:0] d_k, pos_k;
  logic signed [15:0] u_k, fwd_k;

  logic        [34:0] ysum;
  logic signed [35:0] pdiff;
  logic signed [19:0] pitch_new;
  logic        [32:0] r_next;
  logic signed [21:0] a0, a1, a2;
  logic               fold;
  logic signed [33:0] dxs, dys;
  logic signed [31:0] at;
  logic signed [34:0] ysr, xsr;
  logic signed [15:0] sn, cs;
  logic signed [63:0] q14r;
  logic        [33:0] t;
  logic        [5:0]  shamt;
  logic signed [63:0] urnd;
  logic signed [63:0] mv;
  logic signed [33:0] psum;
  logic signed [31:0] pos_new;

  always_comb begin
    case (cmd.k)
      2'd0: begin d_k = d0; pos_k = pos0; u_k = u0; fwd_k = fx; end
      2'd1: begin d_k = d1; pos_k = pos1; u_k = u1; fwd_k = fy; end
      default: begin d_k = d2; pos_k = pos2; u_k = u2; fwd_k = fz; end
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.msel)
      ffc_pkg::M_YAW:   begin ma = 36'(mdx); mb = $signed(36'(look_sensitivity)); end
      ffc_pkg::M_PITCH: begin ma = 36'(mdy); mb = $signed(36'(look_sensitivity)); end
      ffc_pkg::M_FX:    begin ma = 36'(cos_pitch); mb = 36'(sin_yaw); end
      ffc_pkg::M_FZ:    begin ma = 36'(cos_pitch); mb = 36'(cos_yaw); end
      ffc_pkg::M_DA:    begin ma = 36'(fwd_k); mb = 36'(fa); end
      ffc_pkg::M_DB:    begin
        ma = (cmd.k == 2'd0) ? 36'(cos_yaw) : 36'(sin_yaw);
        mb = 36'(ra);
      end
      ffc_pkg::M_SQ:    begin ma = 36'(d_k); mb = 36'(d_k); end
      ffc_pkg::M_YY:    begin ma = $signed(36'(y)); mb = $signed(36'(y)); end
      ffc_pkg::M_MY2:   begin ma = $signed(36'(m[29:0])); mb = $signed(36'(y2)); end
      ffc_pkg::M_YF:    begin ma = $signed(36'(y)); mb = $signed(36'(f)); end
      ffc_pkg::M_DY:    begin ma = 36'(d_k); mb = $signed(36'(y)); end
      ffc_pkg::M_SPD:   begin ma = $signed(36'(move_speed)); mb = $signed(36'(boost_factor)); end
      ffc_pkg::M_US:    begin ma = 36'(u_k); mb = $signed(36'(speed)); end
      ffc_pkg::M_PDT:   begin ma = $signed(prod[35:0]); mb = $signed(36'(dt)); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    ysum = {14'd0, yaw} + 35'(prod[34:0]) + ffc_pkg::YAW_BIAS;
    pdiff = 36'(pitch) - 36'($signed(prod[34:0]));
    if (pdiff > 36'(ffc_pkg::PITCH_LIMIT)) pitch_new = 20'(ffc_pkg::PITCH_LIMIT);
    else if (pdiff < -36'(ffc_pkg::PITCH_LIMIT)) pitch_new = -20'(ffc_pkg::PITCH_LIMIT);
    else pitch_new = pdiff[19:0];
    r_next = (r >= dv) ? r - dv : r;

    a0 = (cmd.k == 2'd0) ? $signed({1'b0, yaw}) : 22'(pitch);
    a1 = (a0 > 22'(ffc_pkg::HALF_TURN)) ? a0 - 22'(ffc_pkg::YAW_FULL) : a0;
    fold = 1'b0;
    a2 = a1;
    if (a1 > 22'(ffc_pkg::QUARTER)) begin
      a2 = a1 - 22'(ffc_pkg::HALF_TURN);
      fold = 1'b1;
    end else if (a1 < -22'(ffc_pkg::QUARTER)) begin
      a2 = a1 + 22'(ffc_pkg::HALF_TURN);
      fold = 1'b1;
    end

    dxs = cyv >>> cmd.step;
    dys = cx >>> cmd.step;
    at = $signed(32'(ffc_pkg::atan_deg20(cmd.step)));

    ysr = (35'(cyv) + 35'sd32768) >>> 16;
    xsr = (35'(cx) + 35'sd32768) >>> 16;
    sn = clamp_q14(64'(ysr));
    cs = clamp_q14(64'(xsr));
    if (cneg) begin
      sn = -sn;
      cs = -cs;
    end

    q14r = 64'(clamp_q14(($signed(prod[63:0]) + 64'sd8192) >>> 14));

    t = prod[61:28];
    shamt = 6'(7'sd30 + (sh >>> 1));
    urnd = ($signed(prod[63:0]) + (64'sd1 <<< (shamt - 6'd1))) >>> shamt;

    mv = ($signed(prod[63:0]) + 64'sd2097152) >>> 22;
    psum = 34'(pos_k) + 34'(mv);
    if (psum > 34'sd2147483647) pos_new = 32'sh7FFFFFFF;
    else if (psum < -34'sd2147483648) pos_new = 32'sh80000000;
    else pos_new = psum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw       <= '0;
      pitch     <= '0;
      pos0      <= '0;
      pos1      <= '0;
      pos2      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        ffc_pkg::OP_PITCH: pitch <= pitch_new;
        ffc_pkg::OP_MOD:   yaw <= r_next[20:0];
        ffc_pkg::OP_MOVE: begin
          case (cmd.k)
            2'd0:    pos0 <= pos_new;
            2'd1:    pos1 <= pos_new;
            default: pos2 <= pos_new;
          endcase
        end
        default: ;
      endcase
      if (cmd.op == ffc_pkg::OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ffc_pkg::OP_LOAD: begin
        fa <= forward_axis; ra <= right_axis; ua <= up_axis;
        dt <= time_step; boost <= boost_on; mdx <= mouse_dx; mdy <= mouse_dy;
      end
      ffc_pkg::OP_MUL:   prod <= ma * mb;
      ffc_pkg::OP_YPREP: begin r <= ysum[32:0]; dv <= ffc_pkg::YAW_DV0; end
      ffc_pkg::OP_MOD:   begin r <= r_next; dv <= dv >> 1; end
      ffc_pkg::OP_CINIT: begin
        cx <= 34'(ffc_pkg::CORDIC_X0);
        cyv <= '0;
        cz <= 32'(a2) <<< 8;
        cneg <= fold;
      end
      ffc_pkg::OP_CSTEP: begin
        if (cz >= 0) begin
          cx <= cx - dxs; cyv <= cyv + dys; cz <= cz - at;
        end else begin
          cx <= cx + dxs; cyv <= cyv - dys; cz <= cz + at;
        end
      end
      ffc_pkg::OP_CDONE: begin
        if (cmd.k == 2'd0) begin
          sin_yaw <= sn; cos_yaw <= cs;
        end else begin
          sin_pitch <= sn; cos_pitch <= cs;
        end
      end
      ffc_pkg::OP_FX: fx <= q14r[15:0];
      ffc_pkg::OP_FZ: begin fz <= q14r[15:0]; fy <= sin_pitch; end
      ffc_pkg::OP_DSET: begin
        case (cmd.k)
          2'd0:    d0 <= prod[31:0];
          2'd1:    d1 <= prod[31:0];
          default: d2 <= prod[31:0];
        endcase
      end
      ffc_pkg::OP_DADD: begin
        case (cmd.k)
          2'd0:    d0 <= d0 + prod[31:0];
          2'd1:    d1 <= d1 + (32'(ua) <<< 14);
          default: d2 <= d2 - prod[31:0];
        endcase
      end
      ffc_pkg::OP_SACC:  s <= ((cmd.k == 2'd0) ? 62'd0 : s) + prod[61:0];
      ffc_pkg::OP_NINIT: begin m <= s; sh <= '0; end
      ffc_pkg::OP_NORM: begin
        if (m[61:30] != '0) begin
          m <= m >> 2; sh <= sh + 7'sd2;
        end else begin
          m <= m << 2; sh <= sh - 7'sd2;
        end
      end
      ffc_pkg::OP_SEED: y <= {2'd0, ffc_pkg::rsqrt_seed(m[29:26] - 4'd4), 15'd0};
      ffc_pkg::OP_NY2:  y2 <= prod[61:30];
      ffc_pkg::OP_NF:   f <= (t >= ffc_pkg::NR_THREE) ? 32'd0 : 32'(ffc_pkg::NR_THREE - t);
      ffc_pkg::OP_NY:   y <= prod[62:31];
      ffc_pkg::OP_UNIT: begin
        case (cmd.k)
          2'd0:    u0 <= clamp_q14(urnd);
          2'd1:    u1 <= clamp_q14(urnd);
          default: u2 <= clamp_q14(urnd);
        endcase
      end
      ffc_pkg::OP_SPEED: speed <= boost ? prod[27:8] : {4'd0, move_speed};
      ffc_pkg::OP_OUT: begin
        pos_x <= pos0; pos_y <= pos1; pos_z <= pos2;
        fwd_x <= fx; fwd_y <= fy; fwd_z <= fz;
        yaw_angle <= yaw; pitch_angle <= pitch;
      end
      default: ;
    endcase
  end

  assign stat.s_zero    = (s == '0);
  assign stat.norm_done = (m[61:30] == '0) && (m[29:28] != 2'd0);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

### hdl/free_fly_camera_pose_update.sv
// One frame at a time through a shared 36x36 multiplier and CORDIC/Newton sequencer.
// Latency varies with the number of normalization shifts and is shorter when the direction
// is zero; a new frame is taken while the last result waits.
// Synchronous reset: angles and position go to zero, configuration registers to their defaults.
module free_fly_camera_pose_update #(
  parameter int CORDIC_STEPS = 16,
  parameter int RSQRT_STEPS  = 3
) (
  input logic            clk,
  input logic            rst,
  ffc_cfg_if.sink        cfg,
  ffc_frame_if.sink      frame_in,
  ffc_pose_if.source     pose_out
);

  logic [15:0] move_speed;
  logic [11:0] boost_factor;
  logic [15:0] look_sensitivity;

  ffc_pkg::ctl_cmd_t  cmd;
  ffc_pkg::ctl_stat_t stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed       <= 16'd1280;
      boost_factor     <= 12'd1024;
      look_sensitivity <= 16'd410;
    end else if (cfg.valid) begin
      case (cfg.index)
        ffc_pkg::CFG_MOVE_SPEED:   move_speed <= cfg.data;
        ffc_pkg::CFG_BOOST_FACTOR: boost_factor <= cfg.data[11:0];
        ffc_pkg::CFG_LOOK_SENS:    look_sensitivity <= cfg.data;
        default: ;
      endcase
    end
  end

  ffc_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .RSQRT_STEPS (RSQRT_STEPS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(frame_in.valid),
    .in_ready(frame_in.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  ffc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .forward_axis    (frame_in.forward_axis),
    .right_axis      (frame_in.right_axis),
    .up_axis         (frame_in.up_axis),
    .time_step       (frame_in.time_step),
    .boost_on        (frame_in.boost_on),
    .mouse_dx        (frame_in.mouse_dx),
    .mouse_dy        (frame_in.mouse_dy),
    .move_speed      (move_speed),
    .boost_factor    (boost_factor),
    .look_sensitivity(look_sensitivity),
    .out_ready       (pose_out.ready),
    .out_valid       (pose_out.valid),
    .pos_x           (pose_out.pos_x),
    .pos_y           (pose_out.pos_y),
    .pos_z           (pose_out.pos_z),
    .fwd_x           (pose_out.fwd_x),
    .fwd_y           (pose_out.fwd_y),
    .fwd_z           (pose_out.fwd_z),
    .yaw_angle       (pose_out.yaw_angle),
    .pitch_angle     (pose_out.pitch_angle)
  );

endmodule

### bench/tb_ifs.sv
`timescale 1ns / 1ps
interface tb_hold_if;
  logic hold;
endinterface

### bench/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int LIMIT = 4000000;
  localparam int ATAN_N = 24;
  localparam int CORDIC_N = 16;
  localparam int NR_N = 3;

  typedef struct {
    logic signed [15:0] fa, ra, ua;
    logic [15:0] dt;
    logic boost;
    logic signed [15:0] mdx, mdy;
  } frame_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] fx, fy, fz;
    logic [20:0] yaw;
    logic signed [19:0] pitch;
  } pose_t;

  typedef struct {
    frame_t f;
    bit known;
    pose_t p;
  } row_t;

  logic clk, rst;
  ffc_cfg_if cfg ();
  ffc_frame_if frame_in ();
  ffc_pose_if pose_out ();
  tb_hold_if rx_ctl ();

  free_fly_camera_pose_update #(
    .CORDIC_STEPS(CORDIC_N), .RSQRT_STEPS(NR_N)
  ) DUT (
    .clk(clk), .rst(rst), .cfg(cfg), .frame_in(frame_in), .pose_out(pose_out)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  longint speed_q8, boost_q8, look_sens;
  longint yaw_m, pitch_m;
  longint pos_m[3];
  pose_t pose_q[$];
  int fails;
  int cycles;

  longint atan_tab[ATAN_N] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7};
  longint seed_tab[12] = '{30894, 27944, 25707, 23930, 22479, 21263, 20225, 19326,
    18537, 17836, 17210, 16646};

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic rotate(input longint ang, output longint sn, output longint cs);
    longint x, y, z, dx, dy, one;
    bit flip;
    one = longint'(ffc_pkg::Q14_ONE);
    x = longint'(ffc_pkg::CORDIC_X0);
    y = 0;
    flip = 0;
    if (ang > ffc_pkg::HALF_TURN) ang -= ffc_pkg::YAW_FULL;
    if (ang > ffc_pkg::QUARTER) begin
      ang -= ffc_pkg::HALF_TURN;
      flip = 1;
    end else if (ang < -ffc_pkg::QUARTER) begin
      ang += ffc_pkg::HALF_TURN;
      flip = 1;
    end
    z = ang * 256;
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    sn = clip(rnd(y, 16), -one, one);
    cs = clip(rnd(x, 16), -one, one);
    if (flip) begin
      sn = -sn;
      cs = -cs;
    end
  endtask

  task automatic unitize(input longint d[3], output longint u[3]);
    longint unsigned s, m, y, y2, t, f, three, a;
    longint one;
    int p, sh;
    one = longint'(ffc_pkg::Q14_ONE);
    s = 0;
    p = 0;
    three = 64'd3 << 30;
    for (int k = 0; k < 3; k++) begin
      a = d[k] < 0 ? -d[k] : d[k];
      s += a * a;
    end
    if (s == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return;
    end
    while (p < 62 && (s >> (p + 1)) != 0) p++;
    sh = (p & 1) ? p - 29 : p - 28;
    m = sh >= 0 ? (s >> sh) : (s << (-sh));
    y = seed_tab[((m >> 26) - 4) % 12] << 15;
    for (int k = 0; k < NR_N; k++) begin
      y2 = (y * y) >> 30;
      t = (m * y2) >> 28;
      f = t >= three ? 0 : three - t;
      y = (y * f) >> 31;
    end
    for (int k = 0; k < 3; k++)
      u[k] = clip(rnd(d[k] * longint'(y), 30 + sh / 2), -one, one);
  endtask

  task automatic advance_pose(input frame_t f, output pose_t r);
    longint sy, cy, sp, cp, fx, fz, spd, mv, one;
    longint d[3], u[3];
    one = longint'(ffc_pkg::Q14_ONE);
    yaw_m = (yaw_m + longint'(f.mdx) * look_sens) % ffc_pkg::YAW_FULL;
    if (yaw_m < 0) yaw_m += ffc_pkg::YAW_FULL;
    pitch_m = clip(pitch_m - longint'(f.mdy) * look_sens,
                   -longint'(ffc_pkg::PITCH_LIMIT), longint'(ffc_pkg::PITCH_LIMIT));
    rotate(yaw_m, sy, cy);
    rotate(pitch_m, sp, cp);
    fx = clip(rnd(cp * sy, 14), -one, one);
    fz = clip(rnd(cp * cy, 14), -one, one);
    d[0] = fx * longint'(f.fa) + cy * longint'(f.ra);
    d[1] = sp * longint'(f.fa) + one * longint'(f.ua);
    d[2] = fz * longint'(f.fa) - sy * longint'(f.ra);
    unitize(d, u);
    spd = f.boost ? (speed_q8 * boost_q8) >> 8 : speed_q8;
    for (int k = 0; k < 3; k++) begin
      mv = rnd(u[k] * spd * longint'(f.dt), 22);
      pos_m[k] = clip(pos_m[k] + mv, -64'sd2147483648, 64'sd2147483647);
    end
    r.px = 32'(pos_m[0]); r.py = 32'(pos_m[1]); r.pz = 32'(pos_m[2]);
    r.fx = 16'(fx); r.fy = 16'(sp); r.fz = 16'(fz);
    r.yaw = 21'(yaw_m); r.pitch = 20'(pitch_m);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    fails++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      ffc_pkg::CFG_MOVE_SPEED: speed_q8 = longint'(val);
      ffc_pkg::CFG_BOOST_FACTOR: boost_q8 = longint'(val[11:0]);
      ffc_pkg::CFG_LOOK_SENS: look_sens = longint'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send(input frame_t f, input bit known, input pose_t want);
    pose_t p;
    int n;
    n = $urandom_range(0, 5);
    if (n > 0) begin
      frame_in.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    frame_in.valid <= 1'b1;
    frame_in.forward_axis <= f.fa;
    frame_in.right_axis <= f.ra;
    frame_in.up_axis <= f.ua;
    frame_in.time_step <= f.dt;
    frame_in.boost_on <= f.boost;
    frame_in.mouse_dx <= f.mdx;
    frame_in.mouse_dy <= f.mdy;
    @(posedge clk);
    while (!frame_in.ready) @(posedge clk);
    advance_pose(f, p);
    if (known && p != want) report("typed row", p.px, want.px);
    pose_q.push_back(p);
  endtask

  task automatic drain();
    frame_in.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic frame_t rand_frame();
    frame_t f;
    int m;
    m = $urandom_range(0, 9);
    f.fa = (m == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
    f.ra = (m == 1) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
    f.ua = (m == 2) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
    if (m == 3) begin
      f.fa = 0; f.ra = 0; f.ua = 0;
    end
    f.dt = (m == 4) ? 16'($urandom) : 16'($urandom_range(0, 4000));
    f.boost = 1'($urandom);
    f.mdx = (m == 5) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
    f.mdy = (m == 6) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
    return f;
  endfunction

  function automatic frame_t mk(int fa, int ra, int ua, int dt, bit b, int dx, int dy);
    frame_t f;
    f.fa = 16'(fa); f.ra = 16'(ra); f.ua = 16'(ua); f.dt = 16'(dt); f.boost = b;
    f.mdx = 16'(dx); f.mdy = 16'(dy);
    return f;
  endfunction

  function automatic pose_t mkp(int px, int py, int pz, int fx, int fy, int fz,
                                int yaw, int pitch);
    pose_t p;
    p.px = px; p.py = py; p.pz = pz; p.fx = 16'(fx); p.fy = 16'(fy); p.fz = 16'(fz);
    p.yaw = 21'(yaw); p.pitch = 20'(pitch);
    return p;
  endfunction

  row_t rows[$];
  pose_t none;

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n;
    pose_out.ready = 0;
    forever begin
      n = $urandom_range(0, 5);
      if (n > 0 || rx_ctl.hold) begin
        pose_out.ready <= 1'b0;
        repeat (n) @(posedge clk);
        while (rx_ctl.hold) @(posedge clk);
      end
      pose_out.ready <= 1'b1;
      @(posedge clk);
      while (!(pose_out.valid && pose_out.ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pose_t w;
    if (!rst && pose_out.valid && pose_out.ready) begin
      if (pose_q.size() == 0) begin
        fails++;
        $display("unexpected pose item at cycle %0d", cycles);
      end else begin
        w = pose_q.pop_front();
        if (pose_out.pos_x !== w.px) report("pos_x", pose_out.pos_x, w.px);
        if (pose_out.pos_y !== w.py) report("pos_y", pose_out.pos_y, w.py);
        if (pose_out.pos_z !== w.pz) report("pos_z", pose_out.pos_z, w.pz);
        if (pose_out.fwd_x !== w.fx) report("fwd_x", pose_out.fwd_x, w.fx);
        if (pose_out.fwd_y !== w.fy) report("fwd_y", pose_out.fwd_y, w.fy);
        if (pose_out.fwd_z !== w.fz) report("fwd_z", pose_out.fwd_z, w.fz);
        if (pose_out.yaw_angle !== w.yaw) report("yaw", pose_out.yaw_angle, w.yaw);
        if (pose_out.pitch_angle !== w.pitch) report("pitch", pose_out.pitch_angle, w.pitch);
      end
    end
  end

  initial begin
    fails = 0;
    rx_ctl.hold = 0;
    rst = 1;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    frame_in.valid = 0; frame_in.forward_axis = 0; frame_in.right_axis = 0;
    frame_in.up_axis = 0; frame_in.time_step = 0; frame_in.boost_on = 0;
    frame_in.mouse_dx = 0; frame_in.mouse_dy = 0;
    speed_q8 = 1280; boost_q8 = 1024; look_sens = 410;
    yaw_m = 0; pitch_m = 0;
    pos_m[0] = 0; pos_m[1] = 0; pos_m[2] = 0;
    none = mkp(0, 0, 0, 0, 0, 0, 0, 0);
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rows.push_back('{mk(0, 0, 0, 65535, 0, 0, 0), 1, mkp(0, 0, 0, 0, 0, 16384, 0, 0)});
    rows.push_back('{mk(16384, 0, 0, 0, 1, 0, 0), 1, mkp(0, 0, 0, 0, 0, 16384, 0, 0)});
    rows.push_back('{mk(16384, 0, 0, 65535, 0, 0, 0), 0, none});
    rows.push_back('{mk(0, 16384, 0, 65535, 1, 0, 0), 0, none});
    rows.push_back('{mk(0, 0, -16384, 65535, 1, 0, 0), 0, none});
    rows.push_back('{mk(-32768, 32767, -32768, 65535, 1, 0, 0), 0, none});
    rows.push_back('{mk(32767, -32768, 32767, 1, 0, 0, 0), 0, none});
    rows.push_back('{mk(0, 0, 0, 100, 0, 0, 32767), 0, none});
    rows.push_back('{mk(0, 0, 0, 100, 0, 0, -32768), 0, none});
    rows.push_back('{mk(16384, 16384, 16384, 65535, 1, 32767, 0), 0, none});
    rows.push_back('{mk(16384, 0, 0, 65535, 1, -32768, 5), 0, none});
    rows.push_back('{mk(-16384, -16384, 0, 65535, 0, 900, -900), 0, none});
    foreach (rows[i]) send(rows[i].f, rows[i].known, rows[i].p);
    drain();

    write_reg(ffc_pkg::CFG_MOVE_SPEED, 16'hFFFF);
    write_reg(ffc_pkg::CFG_BOOST_FACTOR, 16'h0FFF);
    write_reg(ffc_pkg::CFG_LOOK_SENS, 16'hFFFF);
    for (int i = 0; i < 40; i++) send(mk(16384, 16384, 16384, 65535, 1, 300, 1), 0, none);
    send(mk(-16384, -16384, -16384, 65535, 1, 0, 0), 0, none);
    for (int i = 0; i < 40; i++) send(mk(-16384, 0, -16384, 65535, 1, -7, 2), 0, none);
    drain();

    write_reg(ffc_pkg::CFG_MOVE_SPEED, 16'd0);
    write_reg(ffc_pkg::CFG_BOOST_FACTOR, 16'd0);
    write_reg(ffc_pkg::CFG_LOOK_SENS, 16'd0);
    for (int i = 0; i < 10; i++) send(rand_frame(), 0, none);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(ffc_pkg::CFG_MOVE_SPEED, 16'($urandom));
      write_reg(ffc_pkg::CFG_BOOST_FACTOR, 16'($urandom));
      write_reg(ffc_pkg::CFG_LOOK_SENS, 16'($urandom_range(0, 2000)));
      for (int i = 0; i < 200; i++) begin
        if (ph == 1 && i == 50) begin
          fork
            begin
              rx_ctl.hold = 1;
              repeat (600) @(posedge clk);
              rx_ctl.hold = 0;
            end
          join_none
        end
        if (ph == 2 && i == 100) drain();
        send(rand_frame(), 0, none);
      end
      drain();
    end

    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
